// File: src/uvc_payload_frame_assembler_top_defines.svh
// ----------------------------------------------------------------------------
// UVC payload frame assembler - assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef UVC_PAYLOAD_FRAME_ASSEMBLER_TOP_DEFINES_SVH
`define UVC_PAYLOAD_FRAME_ASSEMBLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define UPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked also during reset
`define UPF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define UPF_ASSERT(label, prop, msg)
`define UPF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: src/upf_pkg.sv
// ----------------------------------------------------------------------------
// UVC payload frame assembler - package
// Word types, command format, error codes and register map.
// ----------------------------------------------------------------------------
package upf_pkg;

    localparam int OFFSET_WIDTH = 24;
    localparam int POS_WIDTH    = 12;
    localparam int PADDR_WIDTH  = 3;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    // register map (word index taken from paddr[2])
    localparam logic REG_FRAME_CAPACITY = 1'b0;
    localparam logic [OFFSET_WIDTH-1:0] FRAME_CAPACITY_RESET = OFFSET_WIDTH'(614400);

    // header flag bits
    localparam int FLAG_EOF_BIT = 1;
    localparam int FLAG_ERR_BIT = 6;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_HEADER   = 2'd1;
    localparam logic [1:0] ERR_FLAG     = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    typedef struct packed {
        logic [7:0]           data_byte;
        logic [POS_WIDTH-1:0] payload_length;
        logic                 payload_first;
    } s_payload_t;

    typedef struct packed {
        logic [7:0]              content_byte;
        logic [OFFSET_WIDTH-1:0] byte_offset;
        logic                    has_content;
        logic                    frame_done;
        logic [OFFSET_WIDTH-1:0] frame_size;
        logic [1:0]              error_code;
    } m_payload_t;

    // command from parser to formatter
    typedef struct packed {
        logic [7:0]              data;
        logic [OFFSET_WIDTH-1:0] offset;
        logic                    has_content;
        logic                    frame_done;
        logic [1:0]              error_code;
    } cmd_t;

endpackage

// File: src/upf_front.sv
// ----------------------------------------------------------------------------
// UVC payload frame assembler - front parser
// Tracks payload position and header, checks the payload, keeps the frame
// fill count and issues one command per byte that yields a result.
// ----------------------------------------------------------------------------
`include "uvc_payload_frame_assembler_top_defines.svh"

module upf_front import upf_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  s_payload_t              s_payload,
    input  logic [OFFSET_WIDTH-1:0] frame_capacity,
    input  logic                    fifo_full,
    output logic                    push,
    output cmd_t                    cmd
);

    logic [POS_WIDTH-1:0]    pos_reg, pos_next;
    logic [7:0]              hlen_reg, hlen_next;
    logic [7:0]              hflags_reg, hflags_next;
    logic [OFFSET_WIDTH-1:0] fill_reg, fill_next;
    logic                    disc_reg, disc_next;

    logic                    accept;
    logic [POS_WIDTH-1:0]    pos;
    logic                    disc;
    logic [7:0]              d;
    logic [POS_WIDTH-1:0]    plen;
    logic [POS_WIDTH-1:0]    hlen_ext;
    logic [POS_WIDTH-1:0]    content_len;
    logic [OFFSET_WIDTH-1:0] room;
    logic [7:0]              flags;
    logic                    is_content;
    logic                    is_eof;

    assign s_ready  = !fifo_full;
    assign accept   = s_valid && s_ready;
    assign d        = s_payload.data_byte;
    assign plen     = s_payload.payload_length;
    assign pos      = s_payload.payload_first ? '0 : pos_reg;
    assign disc     = s_payload.payload_first ? 1'b0 : disc_reg;
    assign hlen_ext = {{(POS_WIDTH-8){1'b0}}, hlen_reg};
    assign flags    = (pos == POS_WIDTH'(1)) ? d : hflags_reg;

    // overflow check operands
    assign content_len = plen - hlen_ext;
    assign room        = (fill_reg < frame_capacity) ? (frame_capacity - fill_reg) : '0;

    assign is_content = (pos < plen) && (pos >= hlen_ext);
    assign is_eof     = (pos < plen) && (pos == plen - POS_WIDTH'(1)) && flags[FLAG_EOF_BIT];

    // byte classification
    always_comb begin
        pos_next    = pos_reg;
        hlen_next   = hlen_reg;
        hflags_next = hflags_reg;
        fill_next   = fill_reg;
        disc_next   = disc_reg;
        push        = 1'b0;
        cmd         = '0;
        if (accept) begin
            pos_next  = (pos < POS_MAX) ? pos + POS_WIDTH'(1) : POS_MAX;
            disc_next = disc;
            if (!disc) begin
                if (pos == '0) begin
                    hlen_next = d;
                    if (d < 8'd2 || plen < {{(POS_WIDTH-8){1'b0}}, d}) begin
                        cmd.error_code = ERR_HEADER;
                    end
                end else begin
                    if (pos == POS_WIDTH'(1)) begin
                        hflags_next = d;
                        if (plen < hlen_ext) begin
                            cmd.error_code = ERR_HEADER;
                        end else if (d[FLAG_ERR_BIT]) begin
                            cmd.error_code = ERR_FLAG;
                        end else if ({{(OFFSET_WIDTH-POS_WIDTH){1'b0}}, content_len} > room) begin
                            cmd.error_code = ERR_OVERFLOW;
                        end
                    end
                    if (cmd.error_code == ERR_NONE) begin
                        // offset carries the fill count; the formatter derives the size
                        cmd.data        = is_content ? d : 8'd0;
                        cmd.offset      = fill_reg;
                        cmd.has_content = is_content;
                        cmd.frame_done  = is_eof;
                        if (is_content) begin
                            fill_next = fill_reg + OFFSET_WIDTH'(1);
                        end
                        if (is_eof) begin
                            fill_next = '0;
                        end
                        push = is_content || is_eof;
                    end
                end
                if (cmd.error_code != ERR_NONE) begin
                    disc_next = 1'b1;
                    fill_next = '0;
                    push      = 1'b1;
                end
            end
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            hlen_reg   <= '0;
            hflags_reg <= '0;
            fill_reg   <= '0;
            disc_reg   <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            hlen_reg   <= hlen_next;
            hflags_reg <= hflags_next;
            fill_reg   <= fill_next;
            disc_reg   <= disc_next;
        end
    end

    `UPF_ASSERT(a_err_discards, (push && cmd.error_code != ERR_NONE) |=> disc_reg, "error did not start discard")
    `UPF_ASSERT(a_err_clears_fill, (push && cmd.error_code != ERR_NONE) |=> (fill_reg == '0), "error did not clear frame fill")

endmodule

// File: src/upf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// UVC payload frame assembler - command queue
// Small register queue between the parser and the output formatter.
// ----------------------------------------------------------------------------
`include "uvc_payload_frame_assembler_top_defines.svh"

module upf_cmd_fifo import upf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    cmd_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = mem[rptr_reg];

    // pointers and fill count
    always_comb begin
        wptr_next  = push ? wptr_reg + FIFO_AW'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + FIFO_AW'(1) : rptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_cmd;
        end
    end

    `UPF_ASSERT(a_count_bound, count_reg <= (FIFO_AW+1)'(FIFO_DEPTH), "queue count beyond depth")
    `UPF_ASSERT(a_no_overrun, !(push && full && !pop), "push into full queue")

endmodule

// File: src/upf_back.sv
// ----------------------------------------------------------------------------
// UVC payload frame assembler - output formatter
// Turns queued commands into result words and holds them in the output
// register until taken.
// ----------------------------------------------------------------------------
`include "uvc_payload_frame_assembler_top_defines.svh"

module upf_back import upf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output m_payload_t m_payload
);

    logic       valid_reg, valid_next;
    m_payload_t word_reg;
    m_payload_t word_next;

    assign pop = cmd_valid && (!valid_reg || m_ready);

    // result word formatting
    always_comb begin
        word_next              = '0;
        word_next.content_byte = cmd.has_content ? cmd.data : 8'd0;
        word_next.byte_offset  = cmd.has_content ? cmd.offset : '0;
        word_next.has_content  = cmd.has_content;
        word_next.frame_done   = cmd.frame_done;
        word_next.error_code   = cmd.error_code;
        if (cmd.frame_done) begin
            word_next.frame_size = cmd.has_content ? cmd.offset + OFFSET_WIDTH'(1)
                                                   : cmd.offset;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            word_reg <= word_next;
        end
    end

    assign m_valid   = valid_reg;
    assign m_payload = word_reg;

    `UPF_ASSERT(a_size_only_done, (valid_reg && !word_reg.frame_done) |-> (word_reg.frame_size == '0), "frame size without frame done")

endmodule

// File: src/uvc_payload_frame_assembler_top.sv
// ----------------------------------------------------------------------------
// UVC payload frame assembler - top level
// Strips UVC payload headers, emits content bytes with frame offsets and
// reports frame completion and payload errors.
//
//   channel | prefix | handshake          | word
//   --------+--------+--------------------+--------------------------
//   input   | s_     | valid / ready      | s_payload_t, one byte
//   result  | m_     | valid / ready      | m_payload_t, zero or one
//   config  | p      | APB, pready high   | frame_capacity at 0x0
//
// One byte per cycle while the command queue has room. A byte that yields a
// result is written to the command queue at its accepting edge and shows on
// m_valid once the output register has loaded it from the queue.
// Bytes with no result leave only the parser state changed.
// s_ready drops only while the four-entry command queue is full.
// Reset (aresetn low, synchronous) clears the parser, queue and output valid
// and loads frame_capacity with 614400.
// ----------------------------------------------------------------------------
module uvc_payload_frame_assembler_top import upf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  s_payload_t             s_payload,
    output logic                   m_valid,
    input  logic                   m_ready,
    output m_payload_t             m_payload,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [OFFSET_WIDTH-1:0] cap_reg;
    logic                    cfg_wr;
    logic                    push;
    cmd_t                    push_cmd;
    logic                    fifo_full;
    logic                    pop;
    logic                    fifo_ne;
    cmd_t                    pop_cmd;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FRAME_CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= FRAME_CAPACITY_RESET;
        end else if (cfg_wr) begin
            cap_reg <= pwdata[OFFSET_WIDTH-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_CAPACITY) ? {{(32-OFFSET_WIDTH){1'b0}}, cap_reg}
                                                     : 32'd0;

    upf_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .frame_capacity (cap_reg),
        .fifo_full      (fifo_full),
        .push           (push),
        .cmd            (push_cmd)
    );

    upf_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (fifo_ne),
        .pop_cmd   (pop_cmd)
    );

    upf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (fifo_ne),
        .cmd       (pop_cmd),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// File: tb/upf_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UVC payload frame assembler - result checker
// Watches the byte input, the result channel and the register port. Keeps
// its own model of the deframer, queues the expected result words and
// compares every accepted result with the oldest one, field by field.
// ----------------------------------------------------------------------------
module upf_frame_checker import upf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  s_payload_t             s_payload,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  m_payload_t             m_payload,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]            pwdata,
    output int                     pending,
    output int                     fail_count
);

    localparam int REPORT_MAX = 10;

    // deframer model state
    logic [POS_WIDTH-1:0]    pos_q;
    logic [7:0]              hdr_len_q;
    logic [7:0]              hdr_flags_q;
    logic [OFFSET_WIDTH-1:0] fill_q;
    logic                    skip_q;
    logic [OFFSET_WIDTH-1:0] cap_q;

    m_payload_t pending_words[$];
    int         fails = 0;

    initial begin
        pending    = 0;
        fail_count = 0;
    end

    // abandon the frame and drop the rest of the payload
    function automatic m_payload_t abandon_frame(input logic [1:0] code);
        m_payload_t r;
        r            = '0;
        r.error_code = code;
        skip_q       = 1'b1;
        fill_q       = '0;
        return r;
    endfunction

    // one payload byte in, returns 1 when it yields a result word
    function automatic bit deframe_byte(input s_payload_t w, output m_payload_t r);
        int                      pos;
        int                      plen;
        int                      content;
        logic [OFFSET_WIDTH-1:0] room;
        bit                      emit;
        r    = '0;
        emit = 1'b0;
        plen = int'(w.payload_length);
        if (w.payload_first) begin
            pos    = 0;
            skip_q = 1'b0;
        end else begin
            pos = int'(pos_q);
        end
        pos_q = (pos < int'(POS_MAX)) ? POS_WIDTH'(pos + 1) : POS_MAX;

        if (skip_q)
            return 1'b0;

        // header length byte
        if (pos == 0) begin
            hdr_len_q = w.data_byte;
            if (w.data_byte < 8'd2 || plen < int'(w.data_byte)) begin
                r = abandon_frame(ERR_HEADER);
                return 1'b1;
            end
            return 1'b0;
        end

        // flags byte: header, error flag, then room in the frame
        if (pos == 1) begin
            hdr_flags_q = w.data_byte;
            if (plen < int'(hdr_len_q)) begin
                r = abandon_frame(ERR_HEADER);
                return 1'b1;
            end
            if (hdr_flags_q[FLAG_ERR_BIT]) begin
                r = abandon_frame(ERR_FLAG);
                return 1'b1;
            end
            content = plen - int'(hdr_len_q);
            room    = (fill_q < cap_q) ? cap_q - fill_q : '0;
            if (content > int'(room)) begin
                r = abandon_frame(ERR_OVERFLOW);
                return 1'b1;
            end
        end

        if (pos >= plen)
            return 1'b0;

        if (pos >= int'(hdr_len_q)) begin
            r.content_byte = w.data_byte;
            r.byte_offset  = fill_q;
            r.has_content  = 1'b1;
            fill_q         = fill_q + OFFSET_WIDTH'(1);
            emit           = 1'b1;
        end

        if (pos == plen - 1 && hdr_flags_q[FLAG_EOF_BIT]) begin
            r.frame_done = 1'b1;
            r.frame_size = fill_q;
            fill_q       = '0;
            emit         = 1'b1;
        end
        return emit;
    endfunction

    function automatic string word_text(input m_payload_t w);
        return $sformatf("byte=%02h off=%0d has=%0b done=%0b size=%0d err=%0d",
                         w.content_byte, w.byte_offset, w.has_content,
                         w.frame_done, w.frame_size, w.error_code);
    endfunction

    // sample at the clock edge, compare, then predict
    always @(posedge aclk) begin
        m_payload_t want;
        if (!aresetn) begin
            pos_q       = '0;
            hdr_len_q   = '0;
            hdr_flags_q = '0;
            fill_q      = '0;
            skip_q      = 1'b0;
            cap_q       = FRAME_CAPACITY_RESET;
            pending_words.delete();
        end else begin
            if (psel && penable && pwrite && pready &&
                (paddr >> 2) == PADDR_WIDTH'(REG_FRAME_CAPACITY))
                cap_q = pwdata[OFFSET_WIDTH-1:0];

            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("%0t: unexpected result word: %s", $realtime,
                                 word_text(m_payload));
                end else begin
                    want = pending_words.pop_front();
                    if (m_payload.content_byte !== want.content_byte ||
                        m_payload.byte_offset  !== want.byte_offset  ||
                        m_payload.has_content  !== want.has_content  ||
                        m_payload.frame_done   !== want.frame_done   ||
                        m_payload.frame_size   !== want.frame_size   ||
                        m_payload.error_code   !== want.error_code) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display("%0t: result mismatch\n  exp %s\n  got %s", $realtime,
                                     word_text(want), word_text(m_payload));
                    end
                end
            end

            if (s_valid && s_ready && deframe_byte(s_payload, want))
                pending_words.push_back(want);
        end
        pending    <= pending_words.size();
        fail_count <= fails;
    end

endmodule

// File: tb/tb_uvc_payload_frame_assembler_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UVC payload frame assembler - testbench top
// Drives payload bytes in bursts, stalls the result side on its own pattern,
// programs the frame capacity between traffic phases and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_uvc_payload_frame_assembler_top;
    import upf_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PLEN_MAX     = 3072;
    localparam logic [PADDR_WIDTH-1:0] CAP_ADDR = PADDR_WIDTH'(REG_FRAME_CAPACITY) << 2;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    s_payload_t             s_payload = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    m_payload_t             m_payload;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [PADDR_WIDTH-1:0] paddr     = '0;
    logic [31:0]            pwdata    = '0;
    logic [31:0]            prdata;
    logic                   pready;

    int pending;
    int fail_count;
    int cycles     = 0;
    int burst_left = 0;
    int words_sent = 0;
    bit hold_long  = 1'b0;

    uvc_payload_frame_assembler_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    upf_frame_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one byte, sent in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] d, input int plen, input bit first);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_payload <= s_payload_t'{data_byte: d, payload_length: plen[POS_WIDTH-1:0],
                                  payload_first: first};
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // a payload: length byte, flags byte, then random bytes; nbytes may cut it
    // short or run past its end, jitter gives each byte its own length
    task automatic send_payload(input int hlen, input logic [7:0] flags, input int plen,
                                input int nbytes, input bit jitter);
        logic [7:0] d;
        int         pl;
        for (int i = 0; i < nbytes; i++) begin
            d  = (i == 0) ? hlen[7:0] : (i == 1) ? flags : 8'($urandom);
            pl = jitter ? $urandom_range(1, PLEN_MAX) : plen;
            send_byte(d, pl, i == 0);
        end
    endtask

    task automatic apb_write(input logic [PADDR_WIDTH-1:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering, wait for every expected word, then let the pipeline drain
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // mostly well-formed payloads, some broken ones and some loose bytes
    task automatic random_traffic(input int count);
        int         start;
        int         kind;
        int         hl;
        int         pl;
        logic [7:0] flags;
        start = words_sent;
        while (words_sent - start < count) begin
            kind  = $urandom_range(0, 99);
            flags = 8'($urandom);
            if (kind < 80) begin
                hl = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40)
                                                  : $urandom_range(2, 10);
                pl = hl + $urandom_range(0, 20);
                flags[FLAG_ERR_BIT] = ($urandom_range(0, 14) == 0);
                send_payload(hl, flags, pl, pl, 1'b0);
            end else if (kind < 85) begin
                // runs past its own end
                hl = $urandom_range(2, 6);
                pl = hl + $urandom_range(0, 6);
                flags[FLAG_ERR_BIT] = 1'b0;
                send_payload(hl, flags, pl, pl + $urandom_range(1, 5), 1'b0);
            end else if (kind < 92) begin
                // truncated, any header, any length
                hl = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 8);
                pl = ($urandom_range(0, 1) == 0) ? $urandom_range(1, PLEN_MAX)
                                                 : $urandom_range(1, 16);
                send_payload(hl, flags, pl, $urandom_range(1, 30),
                             $urandom_range(0, 3) == 0);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), $urandom_range(1, PLEN_MAX),
                              1'($urandom_range(0, 1)));
            end
        end
    endtask

    // result side: segments of steady, random and periodic stalls,
    // or one long hold-off on request
    initial begin
        int mode;
        int len;
        @(posedge aclk);
        forever begin
            if (hold_long) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_long = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(20, 200);
                for (int k = 0; k < len && !hold_long; k++) begin
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= 1'($urandom);
                        2: m_ready <= (k % 4) != 0;
                        default: m_ready <= ($urandom_range(0, 7) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first byte after reset counts as position 0 without the first mark
        send_byte(8'd2, 4, 1'b0);
        send_byte(8'h02, 4, 1'b0);
        send_byte(8'h00, 4, 1'b0);
        send_byte(8'hFF, 4, 1'b0);
        // header length below 2, then a byte that must be ignored
        send_byte(8'd1, 1, 1'b1);
        send_byte(8'hAA, 1, 1'b0);
        send_byte(8'd0, 5, 1'b1);
        // header longer than the payload at byte 0
        send_byte(8'd10, 5, 1'b1);
        // header rechecked at byte 1 with its own length, ahead of the error flag
        send_byte(8'd4, 8, 1'b1);
        send_byte(8'h40, 3, 1'b0);
        // error flag wins over end of frame
        send_payload(2, 8'h42, 4, 4, 1'b0);
        // header-only payload closes an empty frame
        send_payload(2, 8'h02, 2, 2, 1'b0);
        // bytes past the end of the payload
        send_payload(3, 8'h02, 5, 8, 1'b0);
        // frame spread over two payloads
        send_payload(2, 8'h00, 4, 4, 1'b0);
        send_payload(4, 8'h02, 6, 6, 1'b0);
        // longest header and length
        send_byte(8'd255, PLEN_MAX, 1'b1);
        send_byte(8'hBD, PLEN_MAX, 1'b0);

        // reset capacity, with a long receiver hold-off under a full-rate burst
        burst_left = 400;
        hold_long  = 1'b1;
        random_traffic(300);

        // zero capacity: empty payload fits, error flag before overflow
        settle();
        apb_write(CAP_ADDR, 32'h0000_0000);
        send_payload(2, 8'h02, 2, 2, 1'b0);
        send_payload(2, 8'h40, 5, 5, 1'b0);
        send_payload(2, 8'h00, 3, 3, 1'b0);
        random_traffic(250);

        // largest capacity, junk in the upper data bits
        settle();
        apb_write(CAP_ADDR, 32'hA5FF_FFFF);
        random_traffic(300);
        send_payload(2, 8'h00, 42, 42, 1'b0);

        // capacity below the current fill: no room at all
        settle();
        apb_write(CAP_ADDR, 32'd30);
        send_payload(2, 8'h00, 2, 2, 1'b0);
        send_payload(2, 8'h02, 3, 3, 1'b0);
        random_traffic(300);

        settle();
        apb_write(CAP_ADDR, ($urandom & 32'hFF00_0000) | $urandom_range(0, 2000));
        random_traffic(250);

        settle();
        apb_write(CAP_ADDR, $urandom);
        random_traffic(250);

        settle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
